>>> sv/bda_pkg.sv
// bda_pkg: shared types and comparison codes for the branch distance accumulator
// no dependencies

package bda_pkg;

    localparam int unsigned DataW = 64;

    typedef enum logic [3:0] {
        FN_EQ       = 4'd0,
        FN_NE       = 4'd1,
        FN_ULT      = 4'd2,
        FN_ULE      = 4'd3,
        FN_UGT      = 4'd4,
        FN_UGE      = 4'd5,
        FN_SLT      = 4'd6,
        FN_SLE      = 4'd7,
        FN_SGT      = 4'd8,
        FN_SGE      = 4'd9,
        FN_MEMCMP   = 4'd10,
        FN_MEMCMP_N = 4'd11
    } func_t;

    localparam logic [DataW-1:0] AllOnes = {DataW{1'b1}};

    // classified item handed from the front to the back
    typedef struct packed {
        logic [DataW-1:0] distance;
        logic             set_end;
    } mid_item_t;

    // finished result waiting for the consumer
    typedef struct packed {
        logic [DataW-1:0] distance;
        logic [DataW-1:0] total;
        logic             all_satisfied;
        logic             end_of_set;
    } out_item_t;

endpackage

>>> sv/bda_fifo.sv
// bda_fifo: small register based queue with push/full and pop/empty
// no dependencies

module bda_fifo #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 4
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    output logic             full,
    input  logic [WIDTH-1:0] wdata,
    input  logic             pop,
    output logic             empty,
    output logic [WIDTH-1:0] rdata
);

    localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CntW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PtrW-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PtrW-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CntW-1:0]  count_reg, count_next;
    logic             do_push, do_pop;

    assign full    = (count_reg == CntW'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rdata   = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= wdata;
        end
    end

endmodule

>>> sv/bda_front.sv
// bda_front: classifies one constraint and works out its branch distance
// depends on bda_pkg

module bda_front
    import bda_pkg::*;
(
    input  logic [3:0]       func,
    input  logic [DataW-1:0] lhs,
    input  logic [DataW-1:0] rhs,
    input  logic             set_end,
    output mid_item_t        item
);

    logic [DataW:0]   diff_ab;
    logic [DataW-1:0] a_minus_b, b_minus_a;
    logic [DataW-1:0] a_minus_b_inc, b_minus_a_inc;
    logic             ult, eq, slt;
    logic [DataW-1:0] dist_val;

    // borrow out of a - b gives the unsigned order
    assign diff_ab   = {1'b0, lhs} - {1'b0, rhs};
    assign a_minus_b = diff_ab[DataW-1:0];
    assign b_minus_a = rhs - lhs;
    assign ult       = diff_ab[DataW];
    assign eq        = (lhs == rhs);
    assign slt       = (lhs[DataW-1] != rhs[DataW-1]) ? lhs[DataW-1] : ult;

    // strict orders add one, stopping at all ones
    assign a_minus_b_inc = (a_minus_b == AllOnes) ? AllOnes : a_minus_b + 1'b1;
    assign b_minus_a_inc = (b_minus_a == AllOnes) ? AllOnes : b_minus_a + 1'b1;

    always_comb
    begin
        case (func)
            FN_EQ:       dist_val = ult ? b_minus_a : a_minus_b;
            FN_NE:       dist_val = eq ? DataW'(1) : '0;
            FN_ULT:      dist_val = ult ? '0 : a_minus_b_inc;
            FN_ULE:      dist_val = (ult || eq) ? '0 : a_minus_b;
            FN_UGT:      dist_val = !(ult || eq) ? '0 : b_minus_a_inc;
            FN_UGE:      dist_val = !ult ? '0 : b_minus_a;
            FN_SLT:      dist_val = slt ? '0 : a_minus_b_inc;
            FN_SLE:      dist_val = (slt || eq) ? '0 : a_minus_b;
            FN_SGT:      dist_val = !(slt || eq) ? '0 : b_minus_a_inc;
            FN_SGE:      dist_val = !slt ? '0 : b_minus_a;
            FN_MEMCMP:   dist_val = lhs ^ DataW'(1);
            FN_MEMCMP_N: dist_val = lhs;
            default:     dist_val = AllOnes;
        endcase
    end

    assign item.distance = dist_val;
    assign item.set_end  = set_end;

endmodule

>>> sv/bda_back.sv
// bda_back: saturating running sum over a constraint set, builds the result item
// depends on bda_pkg

module bda_back
    import bda_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  mid_item_t mid_item,
    input  logic      mid_empty,
    output logic      mid_pop,
    input  logic      out_full,
    output logic      out_push,
    output out_item_t out_item
);

    logic [DataW-1:0] running_sum_reg, running_sum_next;
    logic [DataW:0]   sum_wide;
    logic [DataW-1:0] total;
    logic             advance;

    assign advance  = !mid_empty && !out_full;
    assign mid_pop  = advance;
    assign out_push = advance;

    assign sum_wide = {1'b0, running_sum_reg} + {1'b0, mid_item.distance};
    assign total    = sum_wide[DataW] ? AllOnes : sum_wide[DataW-1:0];

    assign out_item.distance      = mid_item.distance;
    assign out_item.total         = total;
    assign out_item.all_satisfied = mid_item.set_end && (total == '0);
    assign out_item.end_of_set    = mid_item.set_end;

    always_comb
    begin
        running_sum_next = running_sum_reg;
        if (advance)
        begin
            running_sum_next = mid_item.set_end ? '0 : total;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            running_sum_reg <= '0;
        end
        else
        begin
            running_sum_reg <= running_sum_next;
        end
    end

endmodule

>>> sv/branch_distance_accumulator_core.sv
// Branch distance accumulator. One item is one evaluated constraint (comparison code and two
// 64-bit operands); one result item comes out per item, with the constraint's distance, the
// saturating running total of its set, and on the item marking set end whether the total is
// zero, after which the total clears. Both sides behave as queues: push/full on the input,
// empty/pop on the result. One item is accepted per cycle while full is low; the front
// classifies it and works out the distance in the cycle it is accepted, the back adds it into
// the running sum as it leaves the queue between the front and the back, and the result then
// waits in the result queue for the consumer. These two queues let either side stall alone.
// Depends on bda_pkg, bda_fifo, bda_front, bda_back.

module branch_distance_accumulator_core
    import bda_pkg::*;
#(
    parameter int unsigned MID_DEPTH = 4,
    parameter int unsigned OUT_DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    output logic             full,
    input  logic [3:0]       func,
    input  logic [DataW-1:0] lhs,
    input  logic [DataW-1:0] rhs,
    input  logic             set_end,
    output logic             empty,
    input  logic             pop,
    output logic [DataW-1:0] distance,
    output logic [DataW-1:0] total,
    output logic             all_satisfied,
    output logic             end_of_set
);

    mid_item_t front_item, mid_item;
    out_item_t back_item, head_item;
    logic      mid_empty, mid_pop;
    logic      out_full, out_push;

    bda_front u_front (
        .func    (func),
        .lhs     (lhs),
        .rhs     (rhs),
        .set_end (set_end),
        .item    (front_item)
    );

    bda_fifo #(
        .WIDTH ($bits(mid_item_t)),
        .DEPTH (MID_DEPTH)
    ) u_mid_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .full  (full),
        .wdata (front_item),
        .pop   (mid_pop),
        .empty (mid_empty),
        .rdata (mid_item)
    );

    bda_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .mid_item  (mid_item),
        .mid_empty (mid_empty),
        .mid_pop   (mid_pop),
        .out_full  (out_full),
        .out_push  (out_push),
        .out_item  (back_item)
    );

    bda_fifo #(
        .WIDTH ($bits(out_item_t)),
        .DEPTH (OUT_DEPTH)
    ) u_out_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (out_push),
        .full  (out_full),
        .wdata (back_item),
        .pop   (pop),
        .empty (empty),
        .rdata (head_item)
    );

    assign distance      = head_item.distance;
    assign total         = head_item.total;
    assign all_satisfied = head_item.all_satisfied;
    assign end_of_set    = head_item.end_of_set;

endmodule

>>> tb/bda_scoreboard.sv
// bda_scoreboard: watches both queue ports of branch_distance_accumulator_core, predicts each
// result item from the accepted input items and compares field by field
// depends on bda_pkg

`timescale 1ns / 1ps

module bda_scoreboard
    import bda_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic             full,
    input  logic [3:0]       func,
    input  logic [DataW-1:0] lhs,
    input  logic [DataW-1:0] rhs,
    input  logic             set_end,
    input  logic             empty,
    input  logic             pop,
    input  logic [DataW-1:0] distance,
    input  logic [DataW-1:0] total,
    input  logic             all_satisfied,
    input  logic             end_of_set,
    output int               fail_count,
    output int               outstanding
);

    localparam int ReportLimit = 10;

    out_item_t        expected_results[$];
    logic [DataW-1:0] set_sum;

    function automatic logic [DataW-1:0] clamp_add(input logic [DataW-1:0] x,
                                                   input logic [DataW-1:0] y);
        logic [DataW:0] s;
        s = {1'b0, x} + {1'b0, y};
        return s[DataW] ? AllOnes : s[DataW-1:0];
    endfunction

    function automatic logic [DataW-1:0] constraint_distance(input logic [3:0]       f,
                                                             input logic [DataW-1:0] a,
                                                             input logic [DataW-1:0] b);
        logic [DataW-1:0] ab;
        logic [DataW-1:0] ba;
        ab = a - b;
        ba = b - a;
        case (f)
            FN_EQ:       return (a >= b) ? ab : ba;
            FN_NE:       return (a == b) ? 64'd1 : 64'd0;
            FN_ULT:      return (a < b) ? 64'd0 : clamp_add(ab, 64'd1);
            FN_ULE:      return (a <= b) ? 64'd0 : ab;
            FN_UGT:      return (a > b) ? 64'd0 : clamp_add(ba, 64'd1);
            FN_UGE:      return (a >= b) ? 64'd0 : ba;
            FN_SLT:      return ($signed(a) < $signed(b)) ? 64'd0 : clamp_add(ab, 64'd1);
            FN_SLE:      return ($signed(a) <= $signed(b)) ? 64'd0 : ab;
            FN_SGT:      return ($signed(a) > $signed(b)) ? 64'd0 : clamp_add(ba, 64'd1);
            FN_SGE:      return ($signed(a) >= $signed(b)) ? 64'd0 : ba;
            FN_MEMCMP:   return a ^ 64'd1;
            FN_MEMCMP_N: return a;
            default:     return AllOnes;
        endcase
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        out_item_t        want;
        out_item_t        got;
        logic [DataW-1:0] d;
        logic [DataW-1:0] t;
        if (!rst_n)
        begin
            expected_results.delete();
            set_sum     = '0;
            fail_count  <= 0;
            outstanding <= 0;
        end
        else
        begin
            // compare before predicting: a result never leaves in the cycle its item enters
            if (pop && !empty)
            begin
                got = '{distance, total, all_satisfied, end_of_set};
                if (expected_results.size() == 0)
                begin
                    if (fail_count < ReportLimit)
                        $display("%0t: result item with nothing expected: distance=%h total=%h",
                                 $realtime, distance, total);
                    fail_count <= fail_count + 1;
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (got !== want)
                    begin
                        if (fail_count < ReportLimit)
                        begin
                            $display("%0t: mismatch", $realtime);
                            $display("  distance      exp %h got %h", want.distance, got.distance);
                            $display("  total         exp %h got %h", want.total, got.total);
                            $display("  all_satisfied exp %b got %b",
                                     want.all_satisfied, got.all_satisfied);
                            $display("  end_of_set    exp %b got %b",
                                     want.end_of_set, got.end_of_set);
                        end
                        fail_count <= fail_count + 1;
                    end
                end
            end
            if (push && !full)
            begin
                d = constraint_distance(func, lhs, rhs);
                t = clamp_add(set_sum, d);
                want.distance      = d;
                want.total         = t;
                want.all_satisfied = set_end && (t == '0);
                want.end_of_set    = set_end;
                expected_results   = {expected_results, want};
                set_sum = set_end ? '0 : t;
            end
            outstanding <= expected_results.size();
        end
    end

endmodule

>>> tb/tb_top.sv
// tb_top: stimulus and verdict for branch_distance_accumulator_core
// depends on bda_pkg, the core and bda_scoreboard

`timescale 1ns / 1ps

module tb_top;
    import bda_pkg::*;

    localparam int               WatchdogLimit = 4000;
    localparam logic [DataW-1:0] MinNeg        = {1'b1, {(DataW-1){1'b0}}};
    localparam logic [DataW-1:0] MaxPos        = ~MinNeg;

    logic             clk     = 1'b0;
    logic             rst_n   = 1'b0;
    logic             push    = 1'b0;
    logic [3:0]       func    = '0;
    logic [DataW-1:0] lhs     = '0;
    logic [DataW-1:0] rhs     = '0;
    logic             set_end = 1'b0;
    logic             pop     = 1'b0;
    logic             full;
    logic             empty;
    logic [DataW-1:0] distance;
    logic [DataW-1:0] total;
    logic             all_satisfied;
    logic             end_of_set;

    int fail_count;
    int outstanding;
    int sender_idle_pct   = 7;
    int receiver_idle_pct = 88;
    int idle_cycles       = 0;

    branch_distance_accumulator_core u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .push          (push),
        .full          (full),
        .func          (func),
        .lhs           (lhs),
        .rhs           (rhs),
        .set_end       (set_end),
        .empty         (empty),
        .pop           (pop),
        .distance      (distance),
        .total         (total),
        .all_satisfied (all_satisfied),
        .end_of_set    (end_of_set)
    );

    bda_scoreboard u_scoreboard (
        .clk           (clk),
        .rst_n         (rst_n),
        .push          (push),
        .full          (full),
        .func          (func),
        .lhs           (lhs),
        .rhs           (rhs),
        .set_end       (set_end),
        .empty         (empty),
        .pop           (pop),
        .distance      (distance),
        .total         (total),
        .all_satisfied (all_satisfied),
        .end_of_set    (end_of_set),
        .fail_count    (fail_count),
        .outstanding   (outstanding)
    );

    initial
    begin
        forever #4 clk = ~clk;
    end

    always @(posedge clk)
    begin
        pop <= ($urandom_range(0, 99) >= receiver_idle_pct);
    end

    always @(posedge clk)
    begin
        if ((push && !full) || (pop && !empty))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WatchdogLimit)
        begin
            $display("tb_top: errors");
            $finish;
        end
    end

    // push stays high between back-to-back items, lowered only for a gap
    task automatic send_item(input logic [3:0]       f,
                             input logic [DataW-1:0] a,
                             input logic [DataW-1:0] b,
                             input logic             last);
        while ($urandom_range(0, 99) < sender_idle_pct)
        begin
            push <= 1'b0;
            @(posedge clk);
        end
        push    <= 1'b1;
        func    <= f;
        lhs     <= a;
        rhs     <= b;
        set_end <= last;
        @(posedge clk);
        while (full)
            @(posedge clk);
    endtask

    function automatic logic [DataW-1:0] pick_operand();
        case ($urandom_range(0, 3))
            0:
                case ($urandom_range(0, 4))
                    0:       return '0;
                    1:       return AllOnes;
                    2:       return MinNeg;
                    3:       return MaxPos;
                    default: return 64'd1;
                endcase
            1:       return 64'($urandom_range(0, 255));
            default: return {$urandom, $urandom};
        endcase
    endfunction

    task automatic send_random_sets(input int n_items);
        int               sent;
        int               set_len;
        bit               holds;
        logic [3:0]       f;
        logic [DataW-1:0] a;
        logic [DataW-1:0] b;
        sent = 0;
        while (sent < n_items)
        begin
            set_len = $urandom_range(1, 6);
            holds   = ($urandom_range(0, 3) == 0);
            for (int i = 0; i < set_len; i++)
            begin
                a = pick_operand();
                if (holds)
                begin
                    // only relations that are sure to hold, so the set total stays zero
                    case ($urandom_range(0, 6))
                        0:       f = FN_EQ;
                        1:       f = FN_ULE;
                        2:       f = FN_UGE;
                        3:       f = FN_SLE;
                        4:       f = FN_SGE;
                        5:
                        begin
                            f = FN_MEMCMP;
                            a = 64'd1;
                        end
                        default:
                        begin
                            f = FN_MEMCMP_N;
                            a = '0;
                        end
                    endcase
                    b = a;
                end
                else
                begin
                    if ($urandom_range(0, 19) == 0)
                        f = 4'($urandom_range(FN_MEMCMP_N + 1, 15));
                    else
                        f = 4'($urandom_range(FN_EQ, FN_MEMCMP_N));
                    case ($urandom_range(0, 4))
                        0:       b = a;
                        1:       b = a + 64'($urandom_range(0, 3)) - 64'd1;
                        default: b = pick_operand();
                    endcase
                end
                send_item(f, a, b, i == set_len - 1);
                sent++;
            end
        end
    endtask

    initial
    begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_item(FN_EQ,       '0,      '0,      1'b1);
        send_item(FN_EQ,       '0,      AllOnes, 1'b0);
        send_item(FN_EQ,       AllOnes, '0,      1'b0);
        send_item(FN_NE,       64'd5,   64'd5,   1'b1);
        send_item(FN_NE,       AllOnes, '0,      1'b0);
        send_item(FN_ULT,      AllOnes, '0,      1'b0);
        send_item(FN_ULT,      '0,      AllOnes, 1'b1);
        send_item(FN_ULE,      64'd3,   64'd3,   1'b0);
        send_item(FN_UGT,      '0,      AllOnes, 1'b0);
        send_item(FN_UGT,      64'd1,   '0,      1'b0);
        send_item(FN_UGE,      '0,      64'd1,   1'b1);
        send_item(FN_SLT,      MaxPos,  MinNeg,  1'b0);
        send_item(FN_SLT,      MinNeg,  MaxPos,  1'b1);
        send_item(FN_SLE,      MinNeg,  MinNeg,  1'b0);
        send_item(FN_SLE,      '0,      MinNeg,  1'b0);
        send_item(FN_SGT,      MinNeg,  MaxPos,  1'b0);
        send_item(FN_SGE,      MinNeg,  '0,      1'b1);
        send_item(FN_MEMCMP,   64'd1,   AllOnes, 1'b0);
        send_item(FN_MEMCMP,   '0,      '0,      1'b0);
        send_item(FN_MEMCMP,   AllOnes, '0,      1'b1);
        send_item(FN_MEMCMP_N, '0,      AllOnes, 1'b1);
        send_item(FN_MEMCMP_N, AllOnes, '0,      1'b0);
        // unused comparison codes
        for (int c = FN_MEMCMP_N + 1; c < 16; c++)
            send_item(4'(c), '0, '0, c == 15);

        send_random_sets(170);
        sender_idle_pct   = 88;
        receiver_idle_pct = 7;
        send_random_sets(170);
        sender_idle_pct   = 0;
        receiver_idle_pct = 0;
        send_random_sets(170);
        push <= 1'b0;

        while (outstanding != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
        if (fail_count == 0 && outstanding == 0)
            $display("tb_top: clean");
        else
            $display("tb_top: errors");
        $finish;
    end

endmodule

>>> sim.f
sv/bda_pkg.sv
sv/bda_fifo.sv
sv/bda_front.sv
sv/bda_back.sv
sv/branch_distance_accumulator_core.sv
tb/bda_scoreboard.sv
tb/tb_top.sv
